FILE: design/sssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, constants and the segment font for the seven-segment
// scan driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

	localparam int MAX_DIGITS  = 8;
	localparam int MASK_WIDTH  = 16;
	localparam int STORE_DEPTH = 4;
	localparam int POS_W       = 4;
	localparam int SAMPLE_W    = 10;

	typedef logic [3:0]            code_t;
	typedef code_t [STORE_DEPTH-1:0] digits_t;
	typedef logic [MASK_WIDTH-1:0] mask_t;
	typedef logic [POS_W-1:0]      pos_t;

	localparam code_t BLANK_CODE = 4'd10;

	typedef enum logic [1:0] {
		REG_SEGMENT_MAP = 2'd0,
		REG_DIGIT_MAP   = 2'd1,
		REG_DIGIT_COUNT = 2'd2
	} reg_index_t;

	// word builder request
	typedef struct packed {
		logic [31:0] segment_map;
		logic [31:0] digit_map;
		logic [2:0]  position;
		code_t       code;
	} build_req_t;

	// segments a..g in bits 0..6, dp in bit 7; blank codes light nothing
	function automatic logic [7:0] font(input code_t code);
		logic [7:0] segs;
		case (code)
			4'd0:    segs = 8'h3F;
			4'd1:    segs = 8'h06;
			4'd2:    segs = 8'h5B;
			4'd3:    segs = 8'h4F;
			4'd4:    segs = 8'h66;
			4'd5:    segs = 8'h6D;
			4'd6:    segs = 8'h7D;
			4'd7:    segs = 8'h27;
			4'd8:    segs = 8'h7F;
			4'd9:    segs = 8'h6F;
			default: segs = 8'h00;
		endcase
		return segs;
	endfunction

endpackage

FILE: design/sssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_if
// Valid/ready channels: input requests and drive word results.
// ----------------------------------------------------------------------------
interface sssd_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [sssd_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink   (input valid, input op, input sample, output ready);
endinterface

interface sssd_out_if;
	logic              valid;
	logic              ready;
	sssd_pkg::mask_t   drive_mask;
	logic [2:0]        digit_position;

	modport source (output valid, output drive_mask, output digit_position, input ready);
	modport sink   (input valid, input drive_mask, input digit_position, output ready);
endinterface

FILE: design/sssd_digit_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_digit_split
// Scales a converter reading by 2.5 and splits it into four decimal digits
// with leading zero blanking.
// ----------------------------------------------------------------------------
module sssd_digit_split (
	input  logic [sssd_pkg::SAMPLE_W-1:0] sample,
	output sssd_pkg::digits_t             digits
);

	logic [11:0] value;
	logic [1:0]  thou;
	logic [11:0] rem1_full;
	logic [9:0]  rem1;
	logic [15:0] hun_prod;
	logic [3:0]  hun;
	logic [9:0]  rem2_full;
	logic [6:0]  rem2;
	logic [13:0] ten_prod;
	logic [3:0]  ten;
	logic [6:0]  one_full;
	logic        lit_th;
	logic        lit_hu;
	logic        lit_te;

	assign value = {1'b0, sample, 1'b0} + {3'b000, sample[9:1]};

	always_comb begin
		if (value >= 12'd2000) begin
			thou      = 2'd2;
			rem1_full = value - 12'd2000;
		end else if (value >= 12'd1000) begin
			thou      = 2'd1;
			rem1_full = value - 12'd1000;
		end else begin
			thou      = 2'd0;
			rem1_full = value;
		end
	end

	assign rem1 = rem1_full[9:0];

	// /100 via *41 >> 12, exact below 1000
	assign hun_prod  = {6'd0, rem1} * 16'd41;
	assign hun       = hun_prod[15:12];
	assign rem2_full = rem1 - ({6'd0, hun} * 10'd100);
	assign rem2      = rem2_full[6:0];

	// /10 via *103 >> 10, exact below 100
	assign ten_prod  = {7'd0, rem2} * 14'd103;
	assign ten       = ten_prod[13:10];
	assign one_full  = rem2 - ({3'd0, ten} * 7'd10);

	assign lit_th = (thou != 2'd0);
	assign lit_hu = lit_th || (hun != 4'd0);
	assign lit_te = lit_hu || (ten != 4'd0);

	assign digits[0] = lit_th ? {2'b00, thou} : sssd_pkg::BLANK_CODE;
	assign digits[1] = lit_hu ? hun : sssd_pkg::BLANK_CODE;
	assign digits[2] = lit_te ? ten : sssd_pkg::BLANK_CODE;
	assign digits[3] = one_full[3:0];

endmodule

FILE: design/sssd_word_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_word_build
// Forms the active-low shift register word for one digit position.
// ----------------------------------------------------------------------------
module sssd_word_build (
	input  sssd_pkg::build_req_t req,
	output sssd_pkg::mask_t      drive_mask
);

	logic [7:0]      segs;
	sssd_pkg::mask_t clr;

	assign segs = sssd_pkg::font(req.code);

	always_comb begin
		clr = '0;
		clr[req.digit_map[req.position*4 +: 4]] = 1'b1;
		for (int k = 0; k < 8; k++) begin
			if (segs[k]) begin
				clr[req.segment_map[k*4 +: 4]] = 1'b1;
			end
		end
	end

	assign drive_mask = ~clr;

endmodule

FILE: design/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment display scanner: holds a scaled reading as four
// blanked decimal digits and emits one drive word per change of digit.
// ----------------------------------------------------------------------------
// One request is taken every cycle. A request is held in the input
// register and is then processed in a single pass: a sample updates the
// digit store and yields nothing, a tick moves the scan position and, when
// the shown digit changes, writes a drive word into a two-entry output
// buffer, whose head entry is offered on the result channel. Input
// stalls only while both buffer entries are full. Configuration writes take
// effect on the next cycle.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	sssd_in_if.sink             item,
	sssd_out_if.source          result
);

	logic [31:0]          segment_map_q;
	logic [31:0]          digit_map_q;
	logic [3:0]           digit_count_q;

	logic                 valid_s1;
	logic                 op_s1;
	logic [sssd_pkg::SAMPLE_W-1:0] sample_s1;

	sssd_pkg::pos_t       scan_q;
	sssd_pkg::pos_t       shown_q;
	sssd_pkg::digits_t    store_q;

	sssd_pkg::mask_t      mask0_q, mask1_q;
	logic [2:0]           pos0_q, pos1_q;
	logic [1:0]           count_q;

	logic                 go;
	logic                 push;
	logic                 pop;
	logic                 head_load;
	logic [3:0]           eff_count;
	sssd_pkg::pos_t       next_pos;
	sssd_pkg::pos_t       scan_new;
	sssd_pkg::digits_t    split_digits;
	sssd_pkg::build_req_t req;
	sssd_pkg::mask_t      word;

	sssd_digit_split u_split (
		.sample (sample_s1),
		.digits (split_digits)
	);

	assign eff_count = (digit_count_q > 4'(sssd_pkg::MAX_DIGITS))
		? 4'(sssd_pkg::MAX_DIGITS) : digit_count_q;
	assign next_pos  = scan_q + 4'd1;
	assign scan_new  = (next_pos < eff_count) ? next_pos : 4'd0;

	assign req.segment_map = segment_map_q;
	assign req.digit_map   = digit_map_q;
	assign req.position    = scan_new[2:0];
	assign req.code        = (scan_new < 4'(sssd_pkg::STORE_DEPTH))
		? store_q[scan_new[1:0]] : sssd_pkg::BLANK_CODE;

	sssd_word_build u_build (
		.req        (req),
		.drive_mask (word)
	);

	assign go   = valid_s1 && (count_q != 2'd2);
	assign push = go && op_s1 && (eff_count != 4'd0) && (scan_new != shown_q);
	assign pop  = result.valid && result.ready;

	assign head_load = push && (count_q == 2'd0 || (count_q == 2'd1 && pop));

	assign item.ready            = !valid_s1 || go;
	assign result.valid          = (count_q != 2'd0);
	assign result.drive_mask     = mask0_q;
	assign result.digit_position = pos0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_map_q <= 32'h2FED9567;
			digit_map_q   <= 32'h000002AC;
			digit_count_q <= 4'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sssd_pkg::REG_SEGMENT_MAP: segment_map_q <= cfg_data;
				sssd_pkg::REG_DIGIT_MAP:   digit_map_q   <= cfg_data;
				sssd_pkg::REG_DIGIT_COUNT: digit_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1     <= item.op;
			sample_s1 <= item.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= 4'd8;
			shown_q <= 4'd8;
			store_q <= {sssd_pkg::STORE_DEPTH{sssd_pkg::BLANK_CODE}};
		end else if (go) begin
			if (!op_s1) begin
				store_q <= split_digits;
			end else begin
				scan_q <= scan_new;
				if (push) begin
					shown_q <= scan_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// two-entry output buffer, entry 0 is the head
	always_ff @(posedge clk) begin
		if (head_load) begin
			mask0_q <= word;
			pos0_q  <= scan_new[2:0];
		end else if (pop) begin
			mask0_q <= mask1_q;
			pos0_q  <= pos1_q;
		end
		if (push && !head_load) begin
			mask1_q <= word;
			pos1_q  <= scan_new[2:0];
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the seven-segment scan driver. Sample and tick requests go
// into the block, mostly with random gaps, and drive words come back under
// random stalls in most phases, including one long hold-off that fills the
// block. A predictor keeps its own digit store, scan state and bit maps.
// Each drive word is checked field by field against the oldest predicted
// word. Register writes happen only once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
	import sssd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 6;

	// lit segments a..g of digits 9 down to 0
	localparam logic [9:0][6:0] GLYPHS = {7'h6F, 7'h7F, 7'h27, 7'h7D, 7'h6D,
		7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

	typedef struct packed {
		mask_t      mask;
		logic [2:0] position;
	} drive_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	sssd_in_if  req_ch();
	sssd_out_if word_ch();

	seven_segment_scan_driver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (req_ch.sink),
		.result    (word_ch.source)
	);

	// predictor state
	logic [31:0] seg_map;
	logic [31:0] dig_map;
	logic [3:0]  dig_count;
	pos_t        scan_pos;
	pos_t        shown_pos;
	digits_t     digit_codes;

	drive_word_t pending_words[$];
	int          errors;
	int          quiet_cycles;
	bit          tx_gaps;
	bit          rx_stalls;
	int          hold_len;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic mask_t drive_word_for(input pos_t pos);
		mask_t      word;
		code_t      code;
		logic [6:0] segs;
		word = '1;
		word[dig_map[pos[2:0]*4 +: 4]] = 1'b0;
		code = (pos < STORE_DEPTH) ? digit_codes[pos[1:0]] : BLANK_CODE;
		if (code < 4'd10) begin
			segs = GLYPHS[code];
			for (int k = 0; k < 7; k++) begin
				if (segs[k])
					word[seg_map[k*4 +: 4]] = 1'b0;
			end
		end
		return word;
	endfunction

	task automatic predict_request(input logic op, input logic [SAMPLE_W-1:0] smp);
		int   v;
		int   cnt;
		bit   lit;
		pos_t nxt;
		if (!op) begin
			v = smp * 2 + smp / 2;
			lit = (v / 1000) != 0;
			digit_codes[0] = lit ? code_t'(v / 1000) : BLANK_CODE;
			lit = lit || ((v / 100) % 10 != 0);
			digit_codes[1] = lit ? code_t'((v / 100) % 10) : BLANK_CODE;
			lit = lit || ((v / 10) % 10 != 0);
			digit_codes[2] = lit ? code_t'((v / 10) % 10) : BLANK_CODE;
			digit_codes[3] = code_t'(v % 10);
		end else begin
			cnt = (dig_count > MAX_DIGITS) ? MAX_DIGITS : dig_count;
			nxt = scan_pos + 1'b1;
			scan_pos = (nxt < cnt) ? nxt : '0;
			if (cnt != 0 && scan_pos != shown_pos) begin
				shown_pos = scan_pos;
				pending_words.push_back('{mask: drive_word_for(scan_pos),
					position: scan_pos[2:0]});
			end
		end
	endtask

	task automatic send_request(input logic op, input logic [SAMPLE_W-1:0] smp);
		while (tx_gaps && $urandom_range(99) < 12) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.op     <= op;
		req_ch.sample <= smp;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_request(op, smp);
	endtask

	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_request(1'b1, SAMPLE_W'($urandom_range(1023)));
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SEGMENT_MAP: seg_map = data;
			REG_DIGIT_MAP:   dig_map = data;
			REG_DIGIT_COUNT: dig_count = data[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_reset_state;
		send_ticks(3);
		send_request(1'b0, '0);
		send_ticks(4);
		drain();
	endtask

	task automatic test_sample_digits;
		send_request(1'b0, 10'd1023);
		send_ticks(4);
		send_request(1'b0, 10'd400);
		send_ticks(4);
		send_request(1'b0, 10'd40);
		send_ticks(2);
		send_request(1'b0, 10'd4);
		send_request(1'b0, 10'd1);
		send_ticks(4);
		drain();
	endtask

	task automatic test_digit_counts;
		write_reg(REG_DIGIT_COUNT, 32'd0);
		send_ticks(3);
		drain();
		write_reg(REG_DIGIT_COUNT, 32'd1);
		send_ticks(3);
		drain();
		write_reg(REG_DIGIT_COUNT, 32'd8);
		send_request(1'b0, 10'd777);
		send_ticks(9);
		drain();
		write_reg(REG_DIGIT_COUNT, 32'd15);
		send_ticks(9);
		drain();
	endtask

	task automatic test_bit_maps;
		write_reg(REG_SEGMENT_MAP, 32'h0000_0000);
		write_reg(REG_DIGIT_MAP, 32'hFFFF_FFFF);
		send_ticks(8);
		drain();
		write_reg(REG_SEGMENT_MAP, 32'hFFFF_FFFF);
		write_reg(REG_DIGIT_MAP, 32'h0000_0000);
		send_ticks(8);
		drain();
		write_reg(REG_SEGMENT_MAP, 32'h7654_3210);
		write_reg(REG_DIGIT_MAP, 32'hFEDC_BA98);
		write_reg(REG_DIGIT_COUNT, 32'd4);
		send_ticks(4);
		drain();
	endtask

	task automatic test_backpressure;
		write_reg(REG_DIGIT_COUNT, 32'd8);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		hold_len  = 200;
		for (int i = 0; i < 40; i++)
			send_request(($urandom_range(9) != 0), SAMPLE_W'($urandom_range(1023)));
		drain();
	endtask

	task automatic test_random;
		logic [SAMPLE_W-1:0] smp;
		logic [31:0]         cnt;
		for (int ph = 0; ph < 10; ph++) begin
			tx_gaps   = (ph != 3);
			rx_stalls = (ph != 3);
			write_reg(REG_SEGMENT_MAP, $urandom);
			write_reg(REG_DIGIT_MAP, $urandom);
			case ($urandom_range(5))
				0: cnt = 32'd0;
				1: cnt = 32'd1;
				2: cnt = 32'd8;
				3: cnt = 32'd4;
				default: cnt = $urandom_range(15);
			endcase
			write_reg(REG_DIGIT_COUNT, cnt);
			for (int i = 0; i < 110; i++) begin
				case ($urandom_range(9))
					0: smp = '0;
					1: smp = '1;
					default: smp = SAMPLE_W'($urandom_range(1023));
				endcase
				send_request(($urandom_range(99) < 55), smp);
			end
			drain();
		end
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		word_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				word_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			word_ch.ready <= !(rx_stalls && $urandom_range(99) < 12);
		end
	end

	always @(posedge clk) begin : check_words
		drive_word_t want;
		if (arst_n && word_ch.valid && word_ch.ready) begin
			if (pending_words.size() == 0) begin
				$display("%t: unexpected drive word mask %h position %0d", $time,
					word_ch.drive_mask, word_ch.digit_position);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (word_ch.drive_mask !== want.mask) begin
					$display("%t: drive_mask expected %h actual %h", $time,
						want.mask, word_ch.drive_mask);
					errors++;
				end
				if (word_ch.digit_position !== want.position) begin
					$display("%t: digit_position expected %0d actual %0d", $time,
						want.position, word_ch.digit_position);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (word_ch.valid && word_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%t: timeout, no request or drive word moving", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_SEGMENT_MAP;
		cfg_data      <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.op     <= 1'b0;
		req_ch.sample <= '0;
		errors        = 0;
		quiet_cycles  = 0;
		tx_gaps       = 1'b1;
		rx_stalls     = 1'b1;
		hold_len      = 0;
		seg_map       = 32'h2FED_9567;
		dig_map       = 32'h0000_02AC;
		dig_count     = 4'd4;
		scan_pos      = pos_t'(8);
		shown_pos     = pos_t'(8);
		digit_codes   = {STORE_DEPTH{BLANK_CODE}};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_sample_digits();
		test_digit_counts();
		test_bit_maps();
		test_backpressure();
		test_random();

		if (pending_words.size() != 0) begin
			$display("%t: %0d drive words never arrived", $time, pending_words.size());
			errors++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
